FILE: sv/tes_pkg.sv
`default_nettype none
package tes_pkg;

   // Character codes the parser reacts to
   localparam logic [7:0] CH_ESC  = 8'h1B;
   localparam logic [7:0] CH_BEL  = 8'h07;
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LBRK = 8'h5B;
   localparam logic [7:0] CH_RBRK = 8'h5D;
   localparam logic [7:0] CH_BSL  = 8'h5C;
   localparam logic [7:0] CH_LPAR = 8'h28;
   localparam logic [7:0] CH_RPAR = 8'h29;

   // Parser mode, one-hot
   typedef enum logic [5:0] {
      MODE_NORMAL  = 6'b000001,
      MODE_ESC     = 6'b000010,
      MODE_CSI     = 6'b000100,
      MODE_OSC     = 6'b001000,
      MODE_OSC_ESC = 6'b010000,
      MODE_SKIP1   = 6'b100000
   } mode_type;

   // Parser verdict for the word in the input register
   typedef struct packed {
      logic     keep;
      mode_type mode;
   } parse_status_type;

   // Mode that follows the byte right after an ESC
   function automatic mode_type after_escape(input logic [7:0] b);
      mode_type m;
      m = MODE_NORMAL;
      if (b == CH_LBRK) begin
         m = MODE_CSI;
      end else if (b == CH_RBRK) begin
         m = MODE_OSC;
      end else if (b == CH_LPAR || b == CH_RPAR) begin
         m = MODE_SKIP1;
      end
      return m;
   endfunction

endpackage
`default_nettype wire

FILE: sv/tes_parser.sv
`default_nettype none
module tes_parser
   import tes_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       in_byte,
   input  wire logic             last_of_buffer,
   input  wire logic             advance,
   output parse_status_type      status
);

   mode_type mode_ff;
   mode_type mode_in;
   mode_type next_mode;
   logic     keep;

   // Next mode and keep decision for the current byte
   always_comb begin
      next_mode = MODE_NORMAL;
      keep      = 1'b0;
      case (mode_ff)
         MODE_ESC: begin
            next_mode = after_escape(in_byte);
         end
         MODE_CSI: begin
            if (in_byte inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
               next_mode = MODE_NORMAL;
            end else begin
               next_mode = MODE_CSI;
            end
         end
         MODE_OSC: begin
            if (in_byte == CH_BEL) begin
               next_mode = MODE_NORMAL;
            end else if (in_byte == CH_ESC) begin
               next_mode = MODE_OSC_ESC;
            end else begin
               next_mode = MODE_OSC;
            end
         end
         MODE_OSC_ESC: begin
            // ESC not followed by backslash opens a new sequence
            if (in_byte == CH_BSL) begin
               next_mode = MODE_NORMAL;
            end else begin
               next_mode = after_escape(in_byte);
            end
         end
         MODE_SKIP1: begin
            next_mode = MODE_NORMAL;
         end
         default: begin
            if (in_byte == CH_ESC) begin
               next_mode = MODE_ESC;
            end else begin
               next_mode = MODE_NORMAL;
               keep      = (in_byte != CH_CR);
            end
         end
      endcase
   end

   // End of buffer drops any open sequence
   always_comb begin
      mode_in = mode_ff;
      if (advance) begin
         mode_in = last_of_buffer ? MODE_NORMAL : next_mode;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign status = parse_status_type'{keep: keep, mode: mode_ff};

endmodule
`default_nettype wire

FILE: sv/tes_out_reg.sv
`default_nettype none
module tes_out_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire logic [7:0] load_byte,
   output logic            can_load,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // Slot is free when empty or its word leaves this cycle
   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (can_load) begin
         valid_in = load;
         if (load) begin
            byte_in = load_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;

endmodule
`default_nettype wire

FILE: sv/terminal_escape_stripper.sv
// Channel   Ports                                    Direction  Word
// req       req_valid, req_stall, req_in_byte,       in         raw byte, end-of-buffer mark
//           req_last_of_buffer
// rsp       rsp_valid, rsp_stall, rsp_out_byte       out        kept byte (zero or one per req)
//
// One byte per cycle unless rsp stalls; a kept byte passes the input and result registers.
// The parse mode register updates as each byte leaves the input register.
// Reset is synchronous and returns the parser to normal text with both registers empty.
// A stall on rsp holds a kept byte in the input register; dropped bytes never wait.
`default_nettype none
module terminal_escape_stripper
   import tes_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_last_of_buffer,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte
);

   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [7:0]       s1_byte_ff;
   logic [7:0]       s1_byte_in;
   logic             s1_last_ff;
   logic             s1_last_in;
   logic             s1_adv;
   logic             s1_free;
   logic             out_can_load;
   parse_status_type status;

   // Input register leaves when its byte is dropped or the output slot takes it
   assign s1_adv    = s1_valid_ff && (!status.keep || out_can_load);
   assign s1_free   = !s1_valid_ff || s1_adv;
   assign req_stall = !s1_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_byte_in  = s1_byte_ff;
      s1_last_in  = s1_last_ff;
      if (s1_free) begin
         s1_valid_in = req_valid;
         if (req_valid) begin
            s1_byte_in = req_in_byte;
            s1_last_in = req_last_of_buffer;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
      s1_last_ff <= s1_last_in;
   end

   // Escape-sequence parser
   tes_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .in_byte        (s1_byte_ff),
      .last_of_buffer (s1_last_ff),
      .advance        (s1_adv),
      .status         (status)
   );

   // Result register
   tes_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .load         (s1_adv && status.keep),
      .load_byte    (s1_byte_ff),
      .can_load     (out_can_load),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte)
   );

   // Checks
   a_mode_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(status.mode))
      else $error("parse mode not one-hot");

   a_last_resets_mode: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=> (status.mode == MODE_NORMAL))
      else $error("mode not normal after end of buffer");

   a_no_ctrl_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_byte != CH_CR && rsp_out_byte != CH_ESC))
      else $error("CR or ESC passed to output");

   a_hold_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> (status.keep && rsp_valid && rsp_stall))
      else $error("input register held without output stall");

endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
   import tes_pkg::*;

   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_WORDS = 650;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } stream_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_last_of_buffer = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;

   stream_word_type send_fifo[$];
   logic [7:0]      kept_bytes[$];
   mode_type        strip_mode = MODE_NORMAL;
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              error_count = 0;
   int              phase_words = 0;
   int              quiet_cycles = 0;

   terminal_escape_stripper u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_in_byte       (req_in_byte),
      .req_last_of_buffer(req_last_of_buffer),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte)
   );

   always #5 clock = ~clock;

   function automatic bit is_letter(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
   endfunction

   // Advance the parser copy by one word; returns 1 if the byte is kept
   function automatic bit strip_keep(input logic [7:0] b, input logic last);
      mode_type intro;
      mode_type nxt;
      bit       keep;
      keep = 1'b0;
      // mode entered by the byte that follows an ESC
      case (b)
         CH_LBRK: intro = MODE_CSI;
         CH_RBRK: intro = MODE_OSC;
         CH_LPAR, CH_RPAR: intro = MODE_SKIP1;
         default: intro = MODE_NORMAL;
      endcase
      case (strip_mode)
         MODE_ESC: nxt = intro;
         MODE_CSI: nxt = is_letter(b) ? MODE_NORMAL : MODE_CSI;
         MODE_OSC: begin
            if (b == CH_BEL) nxt = MODE_NORMAL;
            else if (b == CH_ESC) nxt = MODE_OSC_ESC;
            else nxt = MODE_OSC;
         end
         MODE_OSC_ESC: nxt = (b == CH_BSL) ? MODE_NORMAL : intro;
         MODE_SKIP1: nxt = MODE_NORMAL;
         default: begin
            if (b == CH_ESC) begin
               nxt = MODE_ESC;
            end else begin
               nxt = MODE_NORMAL;
               keep = (b != CH_CR);
            end
         end
      endcase
      strip_mode = last ? MODE_NORMAL : nxt;
      return keep;
   endfunction

   task automatic report_error(input string what, input logic [7:0] want,
                               input logic [7:0] got);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s: expected %02h, got %02h", $realtime, what, want, got);
   endtask

   // Stimulus building
   task automatic queue_word(input logic [7:0] b, input logic last);
      stream_word_type w;
      w.data = b;
      w.last = last;
      send_fifo.push_back(w);
      phase_words++;
   endtask

   // random end-of-buffer mark, so open sequences get cut off now and then
   task automatic queue_byte(input logic [7:0] b);
      queue_word(b, $urandom_range(19) == 0);
   endtask

   // body of an escape sequence, after the ESC itself
   task automatic queue_escape_tail(input int kind);
      logic [7:0] b;
      int         n;
      case (kind)
         0: begin
            queue_byte(CH_LBRK);
            n = $urandom_range(4);
            repeat (n) begin
               if ($urandom_range(1)) begin
                  b = 8'($urandom_range(8'h30, 8'h3F));
               end else begin
                  do b = 8'($urandom); while (is_letter(b));
               end
               queue_byte(b);
            end
            b = $urandom_range(1) ? 8'($urandom_range(8'h41, 8'h5A))
                                  : 8'($urandom_range(8'h61, 8'h7A));
            queue_byte(b);
         end
         1: begin
            queue_byte(CH_RBRK);
            n = $urandom_range(6);
            repeat (n) begin
               do b = 8'($urandom); while (b == CH_BEL || b == CH_ESC);
               queue_byte(b);
            end
            case ($urandom_range(3))
               0, 1: queue_byte(CH_BEL);
               2: begin
                  queue_byte(CH_ESC);
                  queue_byte(CH_BSL);
               end
               default: begin
                  // ESC without backslash opens a new sequence
                  queue_byte(CH_ESC);
                  queue_escape_tail($urandom_range(3));
               end
            endcase
         end
         2: begin
            queue_byte($urandom_range(1) ? CH_LPAR : CH_RPAR);
            queue_byte(8'($urandom));
         end
         default: queue_byte(8'($urandom));
      endcase
   endtask

   task automatic queue_burst();
      logic [7:0] b;
      int         n;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            n = $urandom_range(1, 8);
            repeat (n) begin
               do b = 8'($urandom); while (b == CH_ESC);
               queue_byte(b);
            end
         end
         9: begin
            n = $urandom_range(1, 4);
            repeat (n) queue_byte(8'($urandom));
         end
         default: begin
            queue_byte(CH_ESC);
            queue_escape_tail($urandom_range(3));
         end
      endcase
   endtask

   // Driver: next word goes out once the current one is taken
   always @(posedge clock) begin : driver
      stream_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (send_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            w = send_fifo.pop_front();
            req_valid <= 1'b1;
            req_in_byte <= w.data;
            req_last_of_buffer <= w.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check kept bytes, then predict from the accepted word
   always @(posedge clock) begin : monitor
      logic [7:0] want;
      if (reset) begin
         strip_mode = MODE_NORMAL;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (kept_bytes.size() == 0) begin
               report_error("unexpected kept byte", 8'h00, rsp_out_byte);
            end else begin
               want = kept_bytes.pop_front();
               if (rsp_out_byte !== want)
                  report_error("out_byte mismatch", want, rsp_out_byte);
            end
         end
         if (req_valid && !req_stall) begin
            if (strip_keep(req_in_byte, req_last_of_buffer))
               kept_bytes.push_back(req_in_byte);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** terminal_escape_stripper: FAILED **");
            $finish;
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // plain bytes, extremes, carriage return
      queue_word("A", 1'b0);
      queue_word(8'h00, 1'b0);
      queue_word(8'hFF, 1'b1);
      queue_word(CH_CR, 1'b0);
      // control sequence with CR inside, ended by lowercase letter
      queue_word(CH_ESC, 1'b0);
      queue_word(CH_LBRK, 1'b0);
      queue_word(CH_CR, 1'b0);
      queue_word("z", 1'b0);
      // OS command ended by BEL
      queue_word(CH_ESC, 1'b0);
      queue_word(CH_RBRK, 1'b0);
      queue_word("x", 1'b0);
      queue_word(CH_BEL, 1'b0);
      // OS command ended by ESC backslash
      queue_word(CH_ESC, 1'b0);
      queue_word(CH_RBRK, 1'b0);
      queue_word(CH_ESC, 1'b0);
      queue_word(CH_BSL, 1'b0);
      // ESC inside OS command opens a charset select
      queue_word(CH_ESC, 1'b0);
      queue_word(CH_RBRK, 1'b0);
      queue_word(CH_ESC, 1'b0);
      queue_word(CH_RPAR, 1'b0);
      queue_word("B", 1'b0);
      // two-byte escape
      queue_word(CH_ESC, 1'b0);
      queue_word("c", 1'b0);
      // sequence cut off by end of buffer
      queue_word(CH_ESC, 1'b0);
      queue_word(CH_LBRK, 1'b1);
      queue_word("Z", 1'b0);

      // sender holds off until every kept byte has come out
      wait (send_fifo.size() == 0 && !req_valid && kept_bytes.size() == 0);

      for (int phase = 0; phase < 3; phase++) begin
         @(posedge clock);
         case (phase)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 88;
            end
            1: begin
               send_idle_pct = 88;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase_words = 0;
         while (phase_words < PHASE_WORDS) queue_burst();
         wait (send_fifo.size() == 0 && !req_valid && kept_bytes.size() == 0);
      end

      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("** terminal_escape_stripper: PASSED **");
      end else begin
         $display("** terminal_escape_stripper: FAILED **");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/tes_pkg.sv
sv/tes_parser.sv
sv/tes_out_reg.sv
sv/terminal_escape_stripper.sv
tb/tb.sv
